### rtl/dcd_pkg.sv
package dcd_pkg;

    // Default graph size and width of the vertex fields
    localparam int NODES_DEF = 16;
    localparam int FIELD_W   = 4;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_REV,
        ST_ROOT,
        ST_SCAN,
        ST_POP,
        ST_POP_LOAD
    } dcd_state_t;

    // Commands from controller to datapath, at most one per cycle
    typedef struct packed {
        logic accept_edge;
        logic accept_query;
        logic edge_rev;
        logic root_next;
        logic push_root;
        logic push_scan;
        logic scan_next;
        logic pop;
        logic pop_load;
        logic finish_none;
        logic finish_hit;
    } dcd_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic root_end;
        logic root_visited;
        logic scan_end;
        logic edge_bit;
        logic path_bit;
        logic vis_bit;
        logic stack_last;
    } dcd_sts_t;

endpackage

### rtl/directed_cycle_detector_top.sv
// Edge word: a single write, or a second reverse write when both_ways is set (one adjacency write port).
// Query: DFS scanning one adjacency bit per cycle while in ST_SCAN; the result
//   strobe on done is registered, in the cycle after the end.
// busy stays high for the whole walk; no new word is taken meanwhile.
// Reset (rst_n, async, active low) empties the graph; no clearing pass.
// The receiver cannot stall: cyclic is valid only in the done cycle.
module directed_cycle_detector_top
    import dcd_pkg::*;
#(
    parameter int NODES = NODES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [FIELD_W-1:0] src_node,
    input  logic [FIELD_W-1:0] dst_node,
    input  logic               both_ways,
    output logic               done,
    output logic               cyclic
);

    dcd_cmd_t cmd;
    dcd_sts_t sts;

    // Sequencer
    dcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .both_ways (both_ways),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    // Graph store and search datapath
    dcd_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .src_node (src_node),
        .dst_node (dst_node),
        .sts      (sts),
        .done     (done),
        .cyclic   (cyclic)
    );

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a search");
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type) |=> busy)
        else $error("query accepted but not started");
    a_edge_single: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !req_type && !both_ways) |=> (!busy && !done))
        else $error("single edge word took more than one cycle");
`endif

endmodule

### rtl/dcd_ctrl.sv
module dcd_ctrl
    import dcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       req_type,
    input  logic       both_ways,
    input  dcd_sts_t   sts,
    output dcd_cmd_t   cmd,
    output logic       busy
);

    dcd_state_t state_reg;
    dcd_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type)
                        state_next = ST_ROOT;
                    else if (both_ways)
                        state_next = ST_EDGE_REV;
                end
            end
            ST_EDGE_REV:
                state_next = ST_IDLE;
            ST_ROOT:
            begin
                if (sts.root_end)
                    state_next = ST_IDLE;
                else if (!sts.root_visited)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.scan_end)
                    state_next = ST_POP;
                else if (sts.edge_bit && sts.path_bit)
                    state_next = ST_IDLE;
            end
            ST_POP:
                state_next = sts.stack_last ? ST_ROOT : ST_POP_LOAD;
            ST_POP_LOAD:
                state_next = ST_SCAN;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Command decode
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept_query = req_type;
                    cmd.accept_edge  = !req_type;
                end
            end
            ST_EDGE_REV:
                cmd.edge_rev = 1'b1;
            ST_ROOT:
            begin
                if (sts.root_end)
                    cmd.finish_none = 1'b1;
                else if (sts.root_visited)
                    cmd.root_next = 1'b1;
                else
                    cmd.push_root = 1'b1;
            end
            ST_SCAN:
            begin
                if (sts.scan_end)
                    cmd.pop = 1'b1;
                else if (sts.edge_bit && sts.path_bit)
                    cmd.finish_hit = 1'b1;
                else if (sts.edge_bit && !sts.vis_bit)
                    cmd.push_scan = 1'b1;
                else
                    cmd.scan_next = 1'b1;
            end
            ST_POP:
                cmd.pop = 1'b0;
            ST_POP_LOAD:
                cmd.pop_load = 1'b1;
            default:
                busy = 1'b1;
        endcase
    end

endmodule

### rtl/dcd_datapath.sv
module dcd_datapath
    import dcd_pkg::*;
#(
    parameter int NODES = NODES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dcd_cmd_t           cmd,
    input  logic [FIELD_W-1:0] src_node,
    input  logic [FIELD_W-1:0] dst_node,
    output dcd_sts_t           sts,
    output logic               done,
    output logic               cyclic
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = IW + 1;
    localparam int NW = (IW + 1 > FIELD_W + 1) ? IW + 1 : FIELD_W + 1;

    // Adjacency rows, stack and registered read data
    logic [NODES-1:0] adj_mem [NODES];
    logic [NODES-1:0] row_valid_reg;
    logic [NODES-1:0] row_reg;
    logic             row_ok_reg;
    logic [IW-1:0]    stk_mem [NODES];
    logic [IW-1:0]    stk_rd_reg;

    // Search state
    logic [NODES-1:0] visited_reg;
    logic [NODES-1:0] on_path_reg;
    logic [CW-1:0]    depth_reg;
    logic [CW-1:0]    root_reg;
    logic [CW-1:0]    w_reg;
    logic [IW-1:0]    u_reg;
    logic [IW-1:0]    src_reg;
    logic [IW-1:0]    dst_reg;
    logic             rng_reg;
    logic             done_reg;
    logic             cyclic_reg;

    logic [NW-1:0]    src_ext;
    logic [NW-1:0]    dst_ext;
    logic             in_range;
    logic             adj_we;
    logic [IW-1:0]    wr_row;
    logic [IW-1:0]    wr_col;
    logic [NODES-1:0] wr_onehot;
    logic             adj_re;
    logic [IW-1:0]    push_v;
    logic [IW-1:0]    rd_row;
    logic [IW-1:0]    w_idx;
    logic             push;

    // Vertex fields against the graph size
    assign src_ext  = NW'(src_node);
    assign dst_ext  = NW'(dst_node);
    assign in_range = (src_ext < NW'(NODES)) && (dst_ext < NW'(NODES));

    // Edge write: forward from the ports, reverse from the held word
    assign adj_we    = cmd.accept_edge ? in_range : (cmd.edge_rev && rng_reg);
    assign wr_row    = cmd.accept_edge ? src_ext[IW-1:0] : dst_reg;
    assign wr_col    = cmd.accept_edge ? dst_ext[IW-1:0] : src_reg;
    assign wr_onehot = NODES'(1) << wr_col;

    // Row fetch on push or on return to the parent
    assign push   = cmd.push_root || cmd.push_scan;
    assign push_v = cmd.push_root ? root_reg[IW-1:0] : w_reg[IW-1:0];
    assign rd_row = cmd.pop_load ? stk_rd_reg : push_v;
    assign adj_re = push || cmd.pop_load;
    assign w_idx  = w_reg[IW-1:0];

    // Adjacency memory; a row never written reads as zero
    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            if (row_valid_reg[wr_row])
                adj_mem[wr_row][wr_col] <= 1'b1;
            else
                adj_mem[wr_row] <= wr_onehot;
        end
        if (adj_re)
        begin
            row_reg    <= adj_mem[rd_row];
            row_ok_reg <= row_valid_reg[rd_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_valid_reg <= '0;
        else if (adj_we)
            row_valid_reg[wr_row] <= 1'b1;
    end

    // Search stack
    always_ff @(posedge clk)
    begin
        if (push)
            stk_mem[depth_reg[IW-1:0]] <= push_v;
        if (cmd.pop)
            stk_rd_reg <= stk_mem[IW'(depth_reg - CW'(2))];
    end

    // Held edge word for the reverse write
    always_ff @(posedge clk)
    begin
        if (cmd.accept_edge)
        begin
            src_reg <= src_ext[IW-1:0];
            dst_reg <= dst_ext[IW-1:0];
            rng_reg <= in_range;
        end
    end

    // Marks, depth, scan pointer and root counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
            on_path_reg <= '0;
            depth_reg   <= '0;
            root_reg    <= '0;
            w_reg       <= '0;
            u_reg       <= '0;
        end
        else
        begin
            if (cmd.accept_query)
            begin
                visited_reg <= '0;
                on_path_reg <= '0;
                depth_reg   <= '0;
                root_reg    <= '0;
            end
            if (cmd.root_next)
                root_reg <= root_reg + CW'(1);
            if (push)
            begin
                visited_reg[push_v] <= 1'b1;
                on_path_reg[push_v] <= 1'b1;
                depth_reg           <= depth_reg + CW'(1);
                u_reg               <= push_v;
                w_reg               <= '0;
            end
            if (cmd.scan_next)
                w_reg <= w_reg + CW'(1);
            // leaving u: parent resumes just past it
            if (cmd.pop)
            begin
                on_path_reg[u_reg] <= 1'b0;
                depth_reg          <= depth_reg - CW'(1);
                w_reg              <= CW'(u_reg) + CW'(1);
            end
            if (cmd.pop_load)
                u_reg <= stk_rd_reg;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            cyclic_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish_none || cmd.finish_hit;
            if (cmd.finish_none || cmd.finish_hit)
                cyclic_reg <= cmd.finish_hit;
        end
    end

    // Status; stack_last is looked at just after the pop, when the stack is empty
    assign sts.root_end     = (root_reg == CW'(NODES));
    assign sts.root_visited = visited_reg[root_reg[IW-1:0]];
    assign sts.scan_end     = (w_reg == CW'(NODES));
    assign sts.edge_bit     = row_ok_reg && row_reg[w_idx];
    assign sts.path_bit     = on_path_reg[w_idx];
    assign sts.vis_bit      = visited_reg[w_idx];
    assign sts.stack_last   = (depth_reg == CW'(0));

    assign done   = done_reg;
    assign cyclic = cyclic_reg;

endmodule
